// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. The enclosing module provides clock and
// reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg
// Types and constants shared by the stable sorted priority queue modules.
// ----------------------------------------------------------------------------
package sspq_pkg;

   localparam int CAPACITY    = 16;
   localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int TAG_W       = 32;
   localparam int PRIO_W      = 16;
   localparam int FIELD_CNT_W = 5;

   typedef enum logic [1:0] {
      CMD_ENQ    = 2'd0,
      CMD_DEQ    = 2'd1,
      CMD_PEEK   = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_INS_READ,
      SEQ_INS_CHECK,
      SEQ_INS_PUT,
      SEQ_COMPACT,
      SEQ_HEAD_READ,
      SEQ_HEAD_WAIT,
      SEQ_REPORT
   } state_type;

   typedef struct packed {
      logic [TAG_W-1:0]         tag;
      logic signed [PRIO_W-1:0] prio;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic             done;
      entry_type        head;
      status_type       status;
      logic [CNT_W-1:0] removed;
      logic [CNT_W-1:0] count;
   } result_type;

endpackage

// File: design/sspq_ram.sv
// ----------------------------------------------------------------------------
// sspq_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module sspq_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/sspq_seq.sv
// ----------------------------------------------------------------------------
// sspq_seq
// Command sequencer: walks the entry memory to insert, compact or read the
// head, one memory access of each kind per cycle.
// ----------------------------------------------------------------------------
module sspq_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  sspq_pkg::cmd_type           cmd,
   input  sspq_pkg::entry_type         item,
   input  logic [sspq_pkg::CNT_W-1:0]  occupancy,
   input  sspq_pkg::entry_type         rd_data,
   output sspq_pkg::mem_req_type       mem_req,
   output sspq_pkg::result_type        result,
   output logic                        busy
);

   localparam int CNT_W = sspq_pkg::CNT_W;
   localparam int IDX_W = sspq_pkg::IDX_W;

   sspq_pkg::state_type  state_ff, state_in;
   sspq_pkg::cmd_type    cmd_ff, cmd_in;
   sspq_pkg::entry_type  new_ff, new_in;
   sspq_pkg::entry_type  head_ff, head_in;
   sspq_pkg::status_type status_ff, status_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     keep_ff, keep_in;
   logic                 pend_ff, pend_in;
   logic                 first_ff, first_in;

   logic [CNT_W-1:0] idx_m1;
   logic [CNT_W-1:0] idx_m2;
   logic             is_full;
   logic             is_empty;
   logic             ins_stop;
   logic             cmp_issue;
   logic             cmp_drop;

   assign idx_m1    = idx_ff - CNT_W'(1);
   assign idx_m2    = idx_ff - CNT_W'(2);
   assign is_full   = (occupancy == CNT_W'(sspq_pkg::CAPACITY));
   assign is_empty  = (occupancy == '0);
   // The stored entry stays ahead of the new one when its priority is equal or higher.
   assign ins_stop  = ($signed(rd_data.prio) >= $signed(new_ff.prio));
   assign cmp_issue = (idx_ff < occupancy);
   assign cmp_drop  = (cmd_ff == sspq_pkg::CMD_DEQ) ? first_ff : (rd_data.tag == new_ff.tag);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sspq_pkg::SEQ_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      new_ff    <= new_in;
      head_ff   <= head_in;
      status_ff <= status_in;
      idx_ff    <= idx_in;
      keep_ff   <= keep_in;
      first_ff  <= first_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sspq_pkg::SEQ_IDLE: begin
            if (accept) begin
               case (cmd)
                  sspq_pkg::CMD_ENQ: begin
                     if (is_full) begin
                        state_in = sspq_pkg::SEQ_REPORT;
                     end else if (is_empty) begin
                        state_in = sspq_pkg::SEQ_INS_PUT;
                     end else begin
                        state_in = sspq_pkg::SEQ_INS_READ;
                     end
                  end
                  sspq_pkg::CMD_DEQ: begin
                     state_in = is_empty ? sspq_pkg::SEQ_REPORT : sspq_pkg::SEQ_COMPACT;
                  end
                  sspq_pkg::CMD_PEEK: begin
                     state_in = is_empty ? sspq_pkg::SEQ_REPORT : sspq_pkg::SEQ_HEAD_READ;
                  end
                  default: begin
                     state_in = sspq_pkg::SEQ_COMPACT;
                  end
               endcase
            end
         end
         sspq_pkg::SEQ_INS_READ: begin
            state_in = sspq_pkg::SEQ_INS_CHECK;
         end
         sspq_pkg::SEQ_INS_CHECK: begin
            if (ins_stop) begin
               state_in = sspq_pkg::SEQ_REPORT;
            end else if (idx_ff == CNT_W'(1)) begin
               state_in = sspq_pkg::SEQ_INS_PUT;
            end
         end
         sspq_pkg::SEQ_INS_PUT: begin
            state_in = sspq_pkg::SEQ_REPORT;
         end
         sspq_pkg::SEQ_COMPACT: begin
            if (!cmp_issue) begin
               state_in = sspq_pkg::SEQ_REPORT;
            end
         end
         sspq_pkg::SEQ_HEAD_READ: begin
            state_in = sspq_pkg::SEQ_HEAD_WAIT;
         end
         sspq_pkg::SEQ_HEAD_WAIT: begin
            state_in = sspq_pkg::SEQ_REPORT;
         end
         sspq_pkg::SEQ_REPORT: begin
            state_in = sspq_pkg::SEQ_IDLE;
         end
         default: begin
            state_in = sspq_pkg::SEQ_IDLE;
         end
      endcase
   end

   // Walk registers.
   always_comb begin
      cmd_in    = cmd_ff;
      new_in    = new_ff;
      head_in   = head_ff;
      status_in = status_ff;
      idx_in    = idx_ff;
      keep_in   = keep_ff;
      pend_in   = 1'b0;
      first_in  = first_ff;
      case (state_ff)
         sspq_pkg::SEQ_IDLE: begin
            if (accept) begin
               cmd_in    = cmd;
               new_in    = item;
               head_in   = '0;
               keep_in   = '0;
               first_in  = 1'b1;
               idx_in    = (cmd == sspq_pkg::CMD_ENQ) ? occupancy : '0;
               status_in = sspq_pkg::STATUS_OK;
               if (cmd == sspq_pkg::CMD_ENQ && is_full) begin
                  status_in = sspq_pkg::STATUS_FULL;
               end else if ((cmd == sspq_pkg::CMD_DEQ || cmd == sspq_pkg::CMD_PEEK)
                            && is_empty) begin
                  status_in = sspq_pkg::STATUS_EMPTY;
               end
            end
         end
         sspq_pkg::SEQ_INS_CHECK: begin
            if (!ins_stop) begin
               idx_in = idx_m1;
            end
         end
         sspq_pkg::SEQ_COMPACT: begin
            pend_in = cmp_issue;
            if (cmp_issue) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               first_in = 1'b0;
               if (first_ff && cmd_ff == sspq_pkg::CMD_DEQ) begin
                  head_in = rd_data;
               end
               if (!cmp_drop) begin
                  keep_in = keep_ff + CNT_W'(1);
               end
            end
         end
         sspq_pkg::SEQ_HEAD_WAIT: begin
            head_in = rd_data;
         end
         default: begin
         end
      endcase
   end

   // Memory accesses and result. Inserting writes only above the next read and
   // compaction writes only below it, so no access can see a stale entry.
   always_comb begin
      mem_req        = '0;
      result         = '0;
      result.head    = head_ff;
      result.status  = status_ff;
      case (state_ff)
         sspq_pkg::SEQ_INS_READ: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_m1[IDX_W-1:0];
         end
         sspq_pkg::SEQ_INS_CHECK: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff[IDX_W-1:0];
            if (ins_stop) begin
               mem_req.wr_data = new_ff;
            end else begin
               mem_req.wr_data = rd_data;
               mem_req.rd_en   = (idx_ff > CNT_W'(1));
               mem_req.rd_addr = idx_m2[IDX_W-1:0];
            end
         end
         sspq_pkg::SEQ_INS_PUT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff[IDX_W-1:0];
            mem_req.wr_data = new_ff;
         end
         sspq_pkg::SEQ_COMPACT: begin
            mem_req.rd_en   = cmp_issue;
            mem_req.rd_addr = idx_ff[IDX_W-1:0];
            mem_req.wr_en   = pend_ff && !cmp_drop;
            mem_req.wr_addr = keep_ff[IDX_W-1:0];
            mem_req.wr_data = rd_data;
         end
         sspq_pkg::SEQ_HEAD_READ: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = '0;
         end
         sspq_pkg::SEQ_REPORT: begin
            result.done = 1'b1;
            case (cmd_ff)
               sspq_pkg::CMD_ENQ: begin
                  result.count = (status_ff == sspq_pkg::STATUS_OK)
                                 ? occupancy + CNT_W'(1) : occupancy;
               end
               sspq_pkg::CMD_DEQ: begin
                  result.count = (status_ff == sspq_pkg::STATUS_OK) ? keep_ff : occupancy;
               end
               sspq_pkg::CMD_PEEK: begin
                  result.count = occupancy;
               end
               default: begin
                  result.count   = keep_ff;
                  result.removed = occupancy - keep_ff;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign busy = (state_ff != sspq_pkg::SEQ_IDLE);

endmodule

// File: design/stable_sorted_priority_queue.sv
// From the accepting edge, a refused enqueue or an empty dequeue or peek goes straight to
// the result; a peek reads the head entry first, dequeue and remove walk every entry,
// an enqueue into an empty queue writes at once, else lower entries are moved up in turn.
// The next command is taken in the cycle its predecessor's result is shown, one
// memory walk step per cycle sets the rate. Results cannot be stalled.
// Reset empties the queue at once; the entry memory needs no clearing.
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Priority queue kept sorted in one entry memory, stable for equal priorities.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stable_sorted_priority_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_cmd,
   input  logic [31:0]         req_item_tag,
   input  logic signed [15:0]  req_item_priority,
   output logic                rsp_valid,
   output logic [31:0]         rsp_out_tag,
   output logic signed [15:0]  rsp_out_priority,
   output logic [1:0]          rsp_status,
   output logic [4:0]          rsp_removed_count,
   output logic [4:0]          rsp_entry_count
);

   localparam int CNT_W = sspq_pkg::CNT_W;
   localparam int FCW   = sspq_pkg::FIELD_CNT_W;

   logic                          accept;
   logic                          seq_busy;
   sspq_pkg::entry_type           item;
   sspq_pkg::entry_type           rd_entry;
   logic [sspq_pkg::ENTRY_W-1:0]  ram_rd_data;
   sspq_pkg::mem_req_type         mem_req;
   sspq_pkg::result_type          result;

   logic [CNT_W-1:0]              occupancy_ff, occupancy_in;
   logic                          rsp_valid_ff;
   sspq_pkg::entry_type           rsp_head_ff;
   sspq_pkg::status_type          rsp_status_ff;
   logic [CNT_W-1:0]              rsp_removed_ff;
   logic [CNT_W-1:0]              rsp_count_ff;

   assign accept    = start && !seq_busy;
   assign item.tag  = req_item_tag;
   assign item.prio = req_item_priority;
   assign rd_entry  = ram_rd_data;

   sspq_ram #(
      .WIDTH (sspq_pkg::ENTRY_W),
      .DEPTH (sspq_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   sspq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (sspq_pkg::cmd_type'(req_cmd)),
      .item      (item),
      .occupancy (occupancy_ff),
      .rd_data   (rd_entry),
      .mem_req   (mem_req),
      .result    (result),
      .busy      (seq_busy)
   );

   assign occupancy_in = result.done ? result.count : occupancy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         occupancy_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occupancy_ff <= occupancy_in;
         rsp_valid_ff <= result.done;
      end
   end

   always_ff @(posedge clock) begin
      if (result.done) begin
         rsp_head_ff    <= result.head;
         rsp_status_ff  <= result.status;
         rsp_removed_ff <= result.removed;
         rsp_count_ff   <= result.count;
      end
   end

   assign busy              = seq_busy;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_tag       = rsp_head_ff.tag;
   assign rsp_out_priority  = rsp_head_ff.prio;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_count = FCW'(rsp_removed_ff);
   assign rsp_entry_count   = FCW'(rsp_count_ff);

   `ASSERT_ALWAYS(a_occ_bounded, occupancy_ff <= CNT_W'(sspq_pkg::CAPACITY), "occupancy overflow")
   `ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item did not start work")
   `ASSERT_SAME(a_count_match, rsp_valid, rsp_count_ff == occupancy_ff, "reported count differs")
   `ASSERT_SAME(a_full_count, rsp_valid && rsp_status == sspq_pkg::STATUS_FULL, occupancy_ff == CNT_W'(sspq_pkg::CAPACITY), "full status while not full")

endmodule
